// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the design files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ===== design/erir_pkg.sv =====
// ---------------------------------------------------------------------------
// erir_pkg
// shared types and constants of the emulated ram and interface registers
// ---------------------------------------------------------------------------
`default_nettype none

package erir_pkg;

   // access spaces
   localparam logic [1:0] SPACE_RAM   = 2'd0;
   localparam logic [1:0] SPACE_IFACE = 2'd1;
   localparam logic [1:0] SPACE_CTRL  = 2'd2;

   // access sizes
   localparam logic [1:0] SIZE_BYTE  = 2'd0;
   localparam logic [1:0] SIZE_HALF  = 2'd1;
   localparam logic [1:0] SIZE_WORD  = 2'd2;
   localparam logic [1:0] SIZE_DWORD = 2'd3;

   // ram address handling
   localparam int unsigned RAM_ADDR_BITS = 26;
   localparam int unsigned KIB_BITS      = 13;

   // configuration register index, decoded from paddr[2]
   localparam logic CSR_RAM_KIB = 1'b0;

   // control register file
   localparam int unsigned CTRL_COUNT = 10;
   localparam int unsigned CTRL_IDX_W = 4;
   localparam logic [3:0]  CTRL_LIMIT = 4'(CTRL_COUNT);

   // interface register file
   localparam int unsigned IFACE_COUNT = 5;
   localparam int unsigned IFACE_IDX_W = 3;

   // interface register offsets
   localparam logic [4:0] IFACE_OFS_MODE   = 5'd0;
   localparam logic [4:0] IFACE_OFS_FLAGS  = 5'd4;
   localparam logic [4:0] IFACE_OFS_NOP_A  = 5'd8;
   localparam logic [4:0] IFACE_OFS_SEL    = 5'd12;
   localparam logic [4:0] IFACE_OFS_DATA   = 5'd16;
   localparam logic [4:0] IFACE_OFS_STAT   = 5'd20;
   localparam logic [4:0] IFACE_OFS_NOP_B  = 5'd24;
   localparam logic [4:0] IFACE_OFS_NOP_C  = 5'd28;

   // interface register width masks
   localparam logic [31:0] IFACE_MASK_MODE  = 32'h0000_000F;
   localparam logic [31:0] IFACE_MASK_FLAGS = 32'h0000_007F;
   localparam logic [31:0] IFACE_MASK_SEL   = 32'h0000_0007;
   localparam logic [31:0] IFACE_MASK_DATA  = 32'hFFFF_FFFF;
   localparam logic [31:0] IFACE_MASK_STAT  = 32'h0000_000F;

   // register access command from the sequencer
   typedef struct packed {
      logic       write;
      logic       sel_iface;
      logic       sel_ctrl;
      logic [5:0] ofs;
   } erir_regs_cmd_type;

   // register access answer
   typedef struct packed {
      logic        ok;
      logic [31:0] rdata;
   } erir_regs_rsp_type;

endpackage

`default_nettype wire

// ===== design/erir_ram.sv =====
// ---------------------------------------------------------------------------
// erir_ram
// simple dual-port ram word store, one read and one write port, registered read
// ---------------------------------------------------------------------------
`default_nettype none

module erir_ram #(
   parameter int unsigned DEPTH = 524288,
   parameter int unsigned IDX_W = 19
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [IDX_W-1:0]  rd_idx,
   output logic      [63:0]       rd_data,
   input  wire logic              wr_en,
   input  wire logic [IDX_W-1:0]  wr_idx,
   input  wire logic [63:0]       wr_data
);

   logic [63:0] mem [DEPTH];

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_idx];
      end
   end

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/erir_regs.sv =====
// ---------------------------------------------------------------------------
// erir_regs
// control and interface register files with offset decode and width masks
// ---------------------------------------------------------------------------
`default_nettype none

module erir_regs
   import erir_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire erir_regs_cmd_type cmd,
   input  wire logic [31:0]       wdata,
   output erir_regs_rsp_type      rsp
);

   logic [31:0] ctrl_ff  [CTRL_COUNT];
   logic [31:0] iface_ff [IFACE_COUNT];

   logic [CTRL_IDX_W-1:0]  ctrl_idx;
   logic                   ctrl_hit;
   logic [IFACE_IDX_W-1:0] iface_idx;
   logic [31:0]            iface_mask;
   logic                   iface_hit;
   logic                   iface_nop;
   logic [31:0]            ctrl_rd;
   logic [31:0]            iface_rd;

   // control decode: word aligned, ten entries
   assign ctrl_idx = cmd.ofs[5:2];
   assign ctrl_hit = (cmd.ofs[1:0] == 2'b00) && (ctrl_idx < CTRL_LIMIT);
   assign ctrl_rd  = ctrl_hit ? ctrl_ff[ctrl_idx] : 32'd0;

   // interface decode by offset
   always_comb begin
      iface_idx  = '0;
      iface_mask = '0;
      iface_hit  = 1'b0;
      iface_nop  = 1'b0;
      case (cmd.ofs[4:0])
         IFACE_OFS_MODE: begin
            iface_idx  = 3'd0;
            iface_mask = IFACE_MASK_MODE;
            iface_hit  = 1'b1;
         end
         IFACE_OFS_FLAGS: begin
            iface_idx  = 3'd1;
            iface_mask = IFACE_MASK_FLAGS;
            iface_hit  = 1'b1;
         end
         IFACE_OFS_SEL: begin
            iface_idx  = 3'd2;
            iface_mask = IFACE_MASK_SEL;
            iface_hit  = 1'b1;
         end
         IFACE_OFS_DATA: begin
            iface_idx  = 3'd3;
            iface_mask = IFACE_MASK_DATA;
            iface_hit  = 1'b1;
         end
         IFACE_OFS_STAT: begin
            iface_idx  = 3'd4;
            iface_mask = IFACE_MASK_STAT;
            iface_hit  = 1'b1;
         end
         IFACE_OFS_NOP_A, IFACE_OFS_NOP_B, IFACE_OFS_NOP_C: begin
            iface_nop = 1'b1;
         end
         default: begin
            iface_hit = 1'b0;
         end
      endcase
   end

   assign iface_rd = iface_hit ? (iface_ff[iface_idx] & iface_mask) : 32'd0;

   // answer
   always_comb begin
      rsp.ok    = 1'b0;
      rsp.rdata = 32'd0;
      if (cmd.sel_iface) begin
         rsp.ok    = iface_hit || iface_nop;
         rsp.rdata = iface_rd;
      end else if (cmd.sel_ctrl) begin
         rsp.ok    = ctrl_hit;
         rsp.rdata = ctrl_rd;
      end
   end

   // control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CTRL_COUNT; i++) begin
            ctrl_ff[i] <= '0;
         end
      end else if (cmd.write && cmd.sel_ctrl && ctrl_hit) begin
         ctrl_ff[ctrl_idx] <= wdata;
      end
   end

   // interface register writes, masked to width
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < IFACE_COUNT; i++) begin
            iface_ff[i] <= '0;
         end
      end else if (cmd.write && cmd.sel_iface && iface_hit) begin
         iface_ff[iface_idx] <= wdata & iface_mask;
      end
   end

endmodule

`default_nettype wire

// ===== design/emulated_ram_and_interface_registers.sv =====
// an accepted access moves the sequencer into its access state; the result strobe is
//   registered from that state. No new access is taken while busy: the ram word is read
//   when the access is accepted, then merged and written back through the ram write port
// the result is shown for one cycle and cannot be stalled by the receiver
// reset: control and interface registers clear, ram_kib goes to 4096, ram contents
//   are not cleared and hold unknown data until written
// ---------------------------------------------------------------------------
// emulated_ram_and_interface_registers
// big-endian 64-bit word ram with sub-word read-modify-write, plus register spaces
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module emulated_ram_and_interface_registers
   import erir_pkg::*;
#(
   parameter int unsigned RAM_WORDS = 524288
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // access channel
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_type,
   input  wire logic        req_is_write,
   input  wire logic [1:0]  req_size_code,
   input  wire logic [31:0] req_address,
   input  wire logic [63:0] req_write_data,
   // result channel
   output logic             rsp_strobe,
   output logic [63:0]      rsp_read_data,
   output logic             rsp_accepted,
   // configuration port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int unsigned IDX_W = $clog2(RAM_WORDS);
   localparam logic [23:0] RAM_WORDS_LIM = 24'(RAM_WORDS);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_ACCESS = 1'b1;

   logic                  state_ff, state_in;
   logic [KIB_BITS-1:0]   ram_kib_ff;

   logic [1:0]            type_ff;
   logic                  wr_ff;
   logic [1:0]            sz_ff;
   logic [2:0]            sh_ff, sh_in;
   logic                  miss_ff, miss_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [5:0]            ofs_ff;
   logic [63:0]           wdata_ff;

   logic                  rsp_strobe_ff;
   logic [63:0]           rsp_read_data_ff, rsp_read_data_in;
   logic                  rsp_accepted_ff, rsp_accepted_in;

   logic                  accept;
   logic                  csr_write;
   logic [RAM_ADDR_BITS-1:0] ram_addr;
   logic [2:0]            lane_ofs;
   logic [2:0]            size_m1;

   logic [63:0]           ram_rd_data;
   logic                  ram_wr_en;
   logic [63:0]           ram_wr_data;
   logic [63:0]           size_mask;
   logic [5:0]            shift_bits;
   logic [63:0]           lane_mask;
   logic [63:0]           ram_value;

   erir_regs_cmd_type     regs_cmd;
   erir_regs_rsp_type     regs_rsp;

   // handshakes
   assign busy      = (state_ff == ST_ACCESS);
   assign accept    = start && !busy;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == CSR_RAM_KIB) ? {{(32-KIB_BITS){1'b0}}, ram_kib_ff} : 32'd0;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         ram_kib_ff <= KIB_BITS'(4096);
      end else if (csr_write && (paddr[2] == CSR_RAM_KIB)) begin
         ram_kib_ff <= pwdata[KIB_BITS-1:0];
      end
   end

   // ram address: mask, align, big-endian lane position
   assign ram_addr = req_address[RAM_ADDR_BITS-1:0];

   always_comb begin
      case (req_size_code)
         SIZE_BYTE: size_m1 = 3'd0;
         SIZE_HALF: size_m1 = 3'd1;
         SIZE_WORD: size_m1 = 3'd3;
         default:   size_m1 = 3'd7;
      endcase
   end

   assign lane_ofs = ram_addr[2:0] & ~size_m1;
   assign sh_in    = 3'd7 - lane_ofs - size_m1;
   assign idx_in   = ram_addr[3 +: IDX_W];
   assign miss_in  = (ram_addr[RAM_ADDR_BITS-1:10] >= {3'b000, ram_kib_ff}) ||
                     ({1'b0, ram_addr[RAM_ADDR_BITS-1:3]} >= RAM_WORDS_LIM);

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= (state_ff == ST_ACCESS);
      end
   end

   // latch the access beat
   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff  <= req_type;
         wr_ff    <= req_is_write;
         sz_ff    <= req_size_code;
         sh_ff    <= sh_in;
         miss_ff  <= miss_in;
         idx_ff   <= idx_in;
         ofs_ff   <= req_address[5:0];
         wdata_ff <= req_write_data;
      end
   end

   // ram word store
   erir_ram #(
      .DEPTH (RAM_WORDS),
      .IDX_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_idx  (idx_in),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_idx  (idx_ff),
      .wr_data (ram_wr_data)
   );

   // merge lane into the word read back
   always_comb begin
      case (sz_ff)
         SIZE_BYTE: size_mask = 64'h0000_0000_0000_00FF;
         SIZE_HALF: size_mask = 64'h0000_0000_0000_FFFF;
         SIZE_WORD: size_mask = 64'h0000_0000_FFFF_FFFF;
         default:   size_mask = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
   end

   assign shift_bits  = {sh_ff, 3'b000};
   assign lane_mask   = size_mask << shift_bits;
   assign ram_wr_data = (ram_rd_data & ~lane_mask) | ((wdata_ff & size_mask) << shift_bits);
   assign ram_value   = (ram_rd_data >> shift_bits) & size_mask;
   assign ram_wr_en   = (state_ff == ST_ACCESS) && (type_ff == SPACE_RAM) && wr_ff && !miss_ff;

   // register spaces, 32-bit accesses only
   assign regs_cmd.write     = (state_ff == ST_ACCESS) && wr_ff;
   assign regs_cmd.sel_iface = (type_ff == SPACE_IFACE) && (sz_ff == SIZE_WORD);
   assign regs_cmd.sel_ctrl  = (type_ff == SPACE_CTRL) && (sz_ff == SIZE_WORD);
   assign regs_cmd.ofs       = ofs_ff;

   erir_regs u_regs (
      .clock (clock),
      .reset (reset),
      .cmd   (regs_cmd),
      .wdata (wdata_ff[31:0]),
      .rsp   (regs_rsp)
   );

   // result beat
   always_comb begin
      if (type_ff == SPACE_RAM) begin
         rsp_accepted_in  = 1'b1;
         rsp_read_data_in = (wr_ff || miss_ff) ? 64'd0 : ram_value;
      end else begin
         rsp_accepted_in  = regs_rsp.ok;
         rsp_read_data_in = (regs_rsp.ok && !wr_ff) ? {32'd0, regs_rsp.rdata} : 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_ACCESS) begin
         rsp_read_data_ff <= rsp_read_data_in;
         rsp_accepted_ff  <= rsp_accepted_in;
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_accepted  = rsp_accepted_ff;

   // checks
   `ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy && !rsp_strobe)
   `ASSERT_NEXT(a_access_result, clock, reset, state_ff == ST_ACCESS, rsp_strobe && !busy)
   `ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_strobe && !rsp_accepted, rsp_read_data == 64'd0)
   `ASSERT_IMPLY(a_ram_write_busy, clock, reset, ram_wr_en, busy && !accept)

endmodule

`default_nettype wire

// ===== test/emulated_ram_and_interface_registers_tb.sv =====
// ---------------------------------------------------------------------------
// emulated_ram_and_interface_registers_tb
// Drives bus accesses into the ram, interface and control register spaces and an unused one.
// A scoreboard keeps its own copy of the ram and registers, predicts every
// answer and compares each result beat field by field. The usable ram size
// is stepped through several settings over the apb port, extremes included.
// ---------------------------------------------------------------------------
module emulated_ram_and_interface_registers_tb
   import erir_pkg::*;
();

   localparam int unsigned MEM_WORDS   = 524288;
   localparam int unsigned KIB_RESET   = 4096;
   localparam logic [1:0]  SPACE_NONE  = 2'd3;

   typedef struct {
      logic [63:0] read_data;
      logic        accepted;
   } access_answer_type;

   // scoreboard: shadow ram and registers, queue of answers still owed
   class access_scoreboard;
      logic [63:0]       ram_word [int unsigned];
      logic [7:0]        ram_known [int unsigned];
      logic [31:0]       ctrl_reg [CTRL_COUNT];
      logic [31:0]       iface_reg [IFACE_COUNT];
      logic [12:0]       ram_kib;
      access_answer_type answers_due [$];
      int                errors;

      function new();
         foreach (ctrl_reg[i]) ctrl_reg[i] = '0;
         foreach (iface_reg[i]) iface_reg[i] = '0;
         ram_kib = 13'(KIB_RESET);
         errors  = 0;
      endfunction

      function longint unsigned usable_bytes();
         longint unsigned sz;
         sz = 64'(ram_kib) * 1024;
         return (sz < 64'(MEM_WORDS) * 8) ? sz : 64'(MEM_WORDS) * 8;
      endfunction

      // byte lanes of a word touched by an access, bit k = byte offset k
      function logic [7:0] ram_lanes(logic [1:0] size, logic [25:0] a);
         int unsigned bytes;
         int unsigned ofs;
         bytes = 1 << size;
         ofs   = a[2:0] & ~(bytes - 1);
         return 8'(((1 << bytes) - 1) << ofs);
      endfunction

      // true when a ram read misses or touches only bytes already written
      function bit ram_read_safe(logic [1:0] size, logic [31:0] addr);
         logic [7:0]  lanes;
         int unsigned idx;
         if (64'(addr[25:0]) >= usable_bytes()) return 1'b1;
         idx   = 32'(addr[25:3]);
         lanes = ram_lanes(size, addr[25:0]);
         if (!ram_known.exists(idx)) return 1'b0;
         return (ram_known[idx] & lanes) == lanes;
      endfunction

      // predict the answer of an accepted access and update the shadow state
      function void note_access(logic [1:0] space, logic wr, logic [1:0] size,
                                logic [31:0] addr, logic [63:0] wdata);
         access_answer_type ans;
         logic [25:0]       a;
         logic [63:0]       mask;
         logic [63:0]       word;
         logic [31:0]       rmask;
         int unsigned       bytes;
         int unsigned       ofs;
         int unsigned       shift;
         int unsigned       idx;
         int unsigned       ri;
         ans.read_data = '0;
         ans.accepted  = 1'b0;
         rmask = '0;
         ri    = 0;
         case (space)
            SPACE_RAM: begin
               ans.accepted = 1'b1;
               a     = addr[25:0];
               bytes = 1 << size;
               ofs   = a[2:0] & ~(bytes - 1);
               if (64'(a) < usable_bytes()) begin
                  idx   = 32'(a >> 3);
                  shift = (8 - bytes - ofs) * 8;
                  mask  = (size == SIZE_DWORD) ? '1 : (64'd1 << (bytes * 8)) - 64'd1;
                  word  = ram_word.exists(idx) ? ram_word[idx] : '0;
                  if (wr) begin
                     ram_word[idx]  = (word & ~(mask << shift)) | ((wdata & mask) << shift);
                     ram_known[idx] = (ram_known.exists(idx) ? ram_known[idx] : 8'h00)
                                      | ram_lanes(size, a);
                  end else begin
                     ans.read_data = (word >> shift) & mask;
                  end
               end
            end
            SPACE_IFACE: if (size == SIZE_WORD) begin
               ans.accepted = 1'b1;
               case (addr[4:0])
                  IFACE_OFS_MODE:  begin ri = 0; rmask = IFACE_MASK_MODE;  end
                  IFACE_OFS_FLAGS: begin ri = 1; rmask = IFACE_MASK_FLAGS; end
                  IFACE_OFS_SEL:   begin ri = 2; rmask = IFACE_MASK_SEL;   end
                  IFACE_OFS_DATA:  begin ri = 3; rmask = IFACE_MASK_DATA;  end
                  IFACE_OFS_STAT:  begin ri = 4; rmask = IFACE_MASK_STAT;  end
                  // no-op offsets: accepted, nothing stored, read as zero
                  IFACE_OFS_NOP_A, IFACE_OFS_NOP_B, IFACE_OFS_NOP_C: ri = IFACE_COUNT;
                  default: ans.accepted = 1'b0;
               endcase
               if (ans.accepted && ri < IFACE_COUNT) begin
                  if (wr) iface_reg[ri] = wdata[31:0] & rmask;
                  else ans.read_data = 64'(iface_reg[ri] & rmask);
               end
            end
            SPACE_CTRL: if (size == SIZE_WORD && addr[1:0] == 2'b00
                             && addr[5:2] < CTRL_COUNT) begin
               ans.accepted = 1'b1;
               ri = 32'(addr[5:2]);
               if (wr) ctrl_reg[ri] = wdata[31:0];
               else ans.read_data = 64'(ctrl_reg[ri]);
            end
            default: ;
         endcase
         answers_due.push_back(ans);
      endfunction

      // compare one result beat with the oldest owed answer
      function void check_answer(logic [63:0] data, logic ok);
         access_answer_type want;
         if (answers_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat: read_data %h accepted %b",
                     $time, data, ok);
            return;
         end
         want = answers_due.pop_front();
         if (data !== want.read_data) begin
            errors++;
            $display("%0t: read_data mismatch: expected %h actual %h",
                     $time, want.read_data, data);
         end
         if (ok !== want.accepted) begin
            errors++;
            $display("%0t: accepted mismatch: expected %b actual %b",
                     $time, want.accepted, ok);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_type;
   logic        req_is_write;
   logic [1:0]  req_size_code;
   logic [31:0] req_address;
   logic [63:0] req_write_data;
   logic        rsp_strobe;
   logic [63:0] rsp_read_data;
   logic        rsp_accepted;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   access_scoreboard sb;
   logic             idle_on;

   emulated_ram_and_interface_registers #(
      .RAM_WORDS(MEM_WORDS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_is_write(req_is_write),
      .req_size_code(req_size_code),
      .req_address(req_address),
      .req_write_data(req_write_data),
      .rsp_strobe(rsp_strobe),
      .rsp_read_data(rsp_read_data),
      .rsp_accepted(rsp_accepted),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #3000000;
      $display("emulated_ram_and_interface_registers test failed");
      $finish;
   end

   // result beats, sampled at the edge that ends their cycle
   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_answer(rsp_read_data, rsp_accepted);
   end

   // one access beat, with an optional idle gap in front
   task automatic send_access(input logic [1:0] space, input logic wr,
                              input logic [1:0] size, input logic [31:0] addr,
                              input logic [63:0] wdata);
      int unsigned gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 99) < 28) gap = $urandom_range(1, 3);
      if (gap != 0) begin
         start          <= 1'b0;
         req_type       <= 2'($urandom);
         req_is_write   <= 1'($urandom);
         req_size_code  <= 2'($urandom);
         req_address    <= $urandom;
         req_write_data <= {$urandom, $urandom};
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_type       <= space;
      req_is_write   <= wr;
      req_size_code  <= size;
      req_address    <= addr;
      req_write_data <= wdata;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_access(space, wr, size, addr, wdata);
   endtask

   // stop sending and wait for every owed answer
   task automatic drain();
      start <= 1'b0;
      while (sb.answers_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write ram_kib over apb, then read it back
   task automatic set_ram_kib(input logic [12:0] kib);
      drain();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {CSR_RAM_KIB, 2'b00};
      pwdata  <= {19'($urandom), kib};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.ram_kib = kib;
      // read back
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== {19'b0, kib}) begin
         sb.errors++;
         $display("%0t: ram_kib readback mismatch: expected %h actual %h",
                  $time, {19'b0, kib}, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // stimulus
   initial begin
      int unsigned     kib_plan [8];
      int unsigned     pick;
      longint unsigned base;
      logic [22:0]     widx;
      logic [1:0]      space;
      logic [1:0]      size;
      logic            wr;
      logic [31:0]     addr;
      logic [63:0]     wdata;

      sb = new();
      start          <= 1'b0;
      req_type       <= '0;
      req_is_write   <= 1'b0;
      req_size_code  <= '0;
      req_address    <= '0;
      req_write_data <= '0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      reset          <= 1'b1;
      idle_on = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: big-endian lanes, alignment, top of storage, misses
      send_access(SPACE_RAM, 1'b1, SIZE_DWORD, 32'h0000_0000, 64'h0123_4567_89AB_CDEF);
      send_access(SPACE_RAM, 1'b0, SIZE_BYTE,  32'h0000_0000, '0);
      send_access(SPACE_RAM, 1'b0, SIZE_BYTE,  32'h0000_0007, '1);
      send_access(SPACE_RAM, 1'b0, SIZE_HALF,  32'h0000_0003, '0);
      send_access(SPACE_RAM, 1'b0, SIZE_WORD,  32'h0000_0005, '0);
      send_access(SPACE_RAM, 1'b1, SIZE_BYTE,  32'h0000_0002, 64'hFFFF_FFFF_FFFF_FF5A);
      send_access(SPACE_RAM, 1'b0, SIZE_DWORD, 32'hFC00_0006, '0);
      send_access(SPACE_RAM, 1'b1, SIZE_DWORD, 32'(MEM_WORDS * 8 - 8), '1);
      send_access(SPACE_RAM, 1'b0, SIZE_DWORD, 32'(MEM_WORDS * 8 - 8), '0);
      send_access(SPACE_RAM, 1'b1, SIZE_DWORD, 32'h03FF_FFF8, 64'hA5A5_A5A5_A5A5_A5A5);
      send_access(SPACE_RAM, 1'b0, SIZE_DWORD, 32'h03FF_FFF8, '0);
      // control registers: last slot, out of range, misaligned, wrong width
      send_access(SPACE_CTRL, 1'b1, SIZE_WORD,  32'd36, 64'hFFFF_FFFF_DEAD_BEEF);
      send_access(SPACE_CTRL, 1'b0, SIZE_WORD,  32'd36, '0);
      send_access(SPACE_CTRL, 1'b0, SIZE_WORD,  32'd40, '0);
      send_access(SPACE_CTRL, 1'b1, SIZE_WORD,  32'd2,  '1);
      send_access(SPACE_CTRL, 1'b0, SIZE_DWORD, 32'd0,  '0);
      // interface registers: width masks, no-op offset, unknown offset
      send_access(SPACE_IFACE, 1'b1, SIZE_WORD, 32'(IFACE_OFS_MODE),  '1);
      send_access(SPACE_IFACE, 1'b1, SIZE_WORD, 32'(IFACE_OFS_FLAGS), '1);
      send_access(SPACE_IFACE, 1'b1, SIZE_WORD, 32'(IFACE_OFS_SEL),   '1);
      send_access(SPACE_IFACE, 1'b1, SIZE_WORD, 32'(IFACE_OFS_DATA),  '1);
      send_access(SPACE_IFACE, 1'b1, SIZE_WORD, 32'(IFACE_OFS_STAT),  '1);
      send_access(SPACE_IFACE, 1'b0, SIZE_WORD, 32'(IFACE_OFS_FLAGS), '0);
      send_access(SPACE_IFACE, 1'b0, SIZE_WORD, 32'(IFACE_OFS_NOP_B), '0);
      send_access(SPACE_IFACE, 1'b0, SIZE_WORD, 32'd1, '0);
      // unknown space
      send_access(SPACE_NONE, 1'b0, SIZE_WORD, 32'd0, '0);

      // random phases, one ram size setting each
      kib_plan = '{8191, 0, 1, 2, 4096, 4095, 0, 8191};
      kib_plan[6] = $urandom_range(3, 4094);
      for (int p = 0; p < 8; p++) begin
         set_ram_kib(13'(kib_plan[p]));
         idle_on = (p != 4);
         repeat (116) begin
            wr    = 1'($urandom);
            wdata = {$urandom, $urandom};
            size  = 2'($urandom);
            pick  = $urandom_range(0, 99);
            if (pick < 55) begin
               space = SPACE_RAM;
               // word pools: a few low words for back-to-back hazards, the
               // usable-size boundary, the top of storage, anywhere at all
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: widx = 23'($urandom_range(0, 15));
                  5, 6: begin
                     base = sb.usable_bytes() >> 3;
                     widx = 23'((base >= 4) ? base - 4 + $urandom_range(0, 7)
                                            : $urandom_range(0, 7));
                  end
                  7, 8: widx = 23'(MEM_WORDS - 1 - $urandom_range(0, 15));
                  default: widx = 23'($urandom);
               endcase
               addr = {6'($urandom), widx, 3'($urandom)};
               // never read bytes that were never written
               if (!wr && !sb.ram_read_safe(size, addr)) wr = 1'b1;
            end else if (pick < 75) begin
               space = SPACE_IFACE;
               if ($urandom_range(0, 99) < 85) size = SIZE_WORD;
               addr = $urandom;
               if ($urandom_range(0, 4) != 0) addr[4:0] = 5'(4 * $urandom_range(0, 7));
            end else if (pick < 95) begin
               space = SPACE_CTRL;
               if ($urandom_range(0, 99) < 85) size = SIZE_WORD;
               addr = $urandom;
               if ($urandom_range(0, 4) != 0)
                  addr[5:0] = 6'(4 * $urandom_range(0, CTRL_COUNT - 1));
            end else begin
               space = SPACE_NONE;
               addr  = $urandom;
            end
            send_access(space, wr, size, addr, wdata);
         end
      end

      // wind down and report
      drain();
      repeat (8) @(posedge clock);
      if (sb.errors == 0) begin
         $display("emulated_ram_and_interface_registers test passed");
      end else begin
         $display("emulated_ram_and_interface_registers test failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/erir_pkg.sv
design/erir_ram.sv
design/erir_regs.sv
design/emulated_ram_and_interface_registers.sv
test/emulated_ram_and_interface_registers_tb.sv
